// ===== hdl/gdps_pkg.sv =====
package gdps_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // defaults for top level parameters
    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int WINDOW_TABLE_BITS_DEF = 10;

    // gain and gate constants
    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic signed [17:0] ATTACK_COEF = 18'sd26214;
    localparam logic signed [17:0] RELEASE_COEF = 18'sd1311;
    localparam int GATE_FLOOR_INT = ((2 ** (SAMPLE_BITS - 1)) / 100000) + 1;
    localparam logic [23:0] GATE_FLOOR = 24'(GATE_FLOOR_INT);

    // sine polynomial coefficients, q16
    localparam logic [17:0] SIN_C3 = 18'd307;
    localparam logic [17:0] SIN_C2 = 18'd5223;
    localparam logic [17:0] SIN_C1 = 18'd42334;
    localparam logic [17:0] SIN_C0 = 18'd102944;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAIN_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GATE_ENABLE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GATE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRY_GAIN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_GAIN = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYPASS = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_pair_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_pair_t;

    typedef struct packed {
        logic signed [31:0] phase_step;
        logic [14:0] grain_length;
        logic gate_enable;
        logic [22:0] gate_threshold;
        logic [15:0] dry_gain;
        logic [15:0] wet_gain;
        logic bypass;
    } cfg_t;

endpackage

// ===== hdl/gdps_ram.sv =====
module gdps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== hdl/gdps_core.sv =====
module gdps_core #(
    parameter int HISTORY_DEPTH = gdps_pkg::HISTORY_DEPTH_DEF,
    parameter int WINDOW_TABLE_BITS = gdps_pkg::WINDOW_TABLE_BITS_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH),
    localparam int SB = gdps_pkg::SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gdps_pkg::in_pair_t   item,
    input  gdps_pkg::cfg_t       cfg,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_take,
    output gdps_pkg::out_pair_t  result,
    output logic                 ram_en,
    output logic                 ram_we,
    output logic [AW-1:0]        ram_addr,
    output logic [2*SB-1:0]      ram_wdata,
    input  logic [2*SB-1:0]      ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [3:0] STEP_GATE    = 4'd0;
    localparam logic [3:0] STEP_GAIN    = 4'd1;
    localparam logic [3:0] STEP_DELAY   = 4'd2;
    localparam logic [3:0] STEP_WRITE   = 4'd3;
    localparam logic [3:0] STEP_RD_BA   = 4'd4;
    localparam logic [3:0] STEP_RD_AA   = 4'd5;
    localparam logic [3:0] STEP_RD_BB   = 4'd6;
    localparam logic [3:0] STEP_RD_AB   = 4'd7;
    localparam logic [3:0] STEP_SQUARE  = 4'd8;
    localparam logic [3:0] STEP_INTERP_A = 4'd9;
    localparam logic [3:0] STEP_INTERP_B = 4'd10;
    localparam logic [3:0] STEP_WIN_A   = 4'd11;
    localparam logic [3:0] STEP_WIN_B   = 4'd12;
    localparam logic [3:0] STEP_DRY     = 4'd13;
    localparam logic [3:0] STEP_WET     = 4'd14;
    localparam logic [3:0] STEP_OUT     = 4'd15;

    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);
    localparam int HALF_N = 1 << (WINDOW_TABLE_BITS - 1);
    localparam int FULL_N = 1 << WINDOW_TABLE_BITS;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;

    logic signed [SB-1:0] l_reg, r_reg;
    logic [15:0] gain_reg, gain_next;
    logic [31:0] pha_reg, phb_reg;
    logic [AW-1:0] wp_reg;
    logic wrapped_reg;
    logic att_reg, rel_reg;
    logic signed [50:0] p0_reg, p1_reg;
    logic [AW-1:0] dmoda_reg, dmodb_reg;
    logic [15:0] fa_reg, fb_reg;
    logic [AW-1:0] addr_reg [4];
    logic signed [SB-1:0] hist_l_reg [4];
    logic signed [SB-1:0] hist_r_reg [4];
    logic [16:0] t2a_reg, t2b_reg;
    logic [15:0] wa_reg, wb_reg;
    logic signed [SB:0] tapla_reg, tapra_reg, taplb_reg, taprb_reg;
    logic signed [50:0] accl_reg, accr_reg;
    logic signed [SB+1:0] tl_reg, tr_reg;
    gdps_pkg::out_pair_t res_reg;

    logic signed [32:0] a0, a1;
    logic signed [17:0] b0, b1;
    logic signed [50:0] prod0, prod1;

    // delay modulo depth, quotient stays below 16
    function automatic logic [AW-1:0] mod_depth(input logic [15:0] x);
        logic [19:0] v;
        v = {4'b0, x};
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (20'(HISTORY_DEPTH) << k))
            begin
                v = v - (20'(HISTORY_DEPTH) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // folded window argument, 0..65536
    function automatic logic [16:0] win_arg(input logic [31:0] ph);
        logic [WINDOW_TABLE_BITS-1:0] i;
        logic [WINDOW_TABLE_BITS:0] u;
        i = ph[31 -: WINDOW_TABLE_BITS];
        if ({1'b0, i} <= (WINDOW_TABLE_BITS + 1)'(HALF_N))
        begin
            u = {1'b0, i};
        end
        else
        begin
            u = (WINDOW_TABLE_BITS + 1)'(FULL_N) - {1'b0, i};
        end
        return 17'(u) << (17 - WINDOW_TABLE_BITS);
    endfunction

    // entries never written read as zero
    function automatic logic entry_ok(input logic [AW-1:0] a, input logic [AW-1:0] wp,
                                      input logic wr);
        return wr || (a <= wp);
    endfunction

    function automatic logic signed [SB-1:0] sat(input logic signed [51:0] x);
        logic signed [51:0] mx;
        logic signed [51:0] mn;
        mx = 52'sd8388607;
        mn = -52'sd8388608;
        if (x > mx)
        begin
            return SB'(mx);
        end
        else if (x < mn)
        begin
            return SB'(mn);
        end
        return SB'(x);
    endfunction

    // gate decision
    logic [SB-1:0] mag_l, mag_r, peak;
    logic gate_open;

    always_comb
    begin
        mag_l = l_reg[SB-1] ? SB'(-l_reg) : SB'(l_reg);
        mag_r = r_reg[SB-1] ? SB'(-r_reg) : SB'(r_reg);
        peak = (mag_l > mag_r) ? mag_l : mag_r;
        gate_open = (peak >= SB'(cfg.gate_threshold)) && (peak >= gdps_pkg::GATE_FLOOR);
    end

    // values derived from the previous product, the phases and the write position
    logic [31:0] att_inc, rel_inc;
    logic [16:0] ta, tb;
    logic signed [50:0] rs0, rs1;
    logic signed [51:0] sum0, sum1;
    logic [AW:0] ba_w, bb_w;
    logic [AW-1:0] ba, aa, bb, ab;
    logic signed [SB-1:0] gl, gr;

    always_comb
    begin
        att_inc = (p0_reg[31:0] + 32'd65535) >> 16;
        rel_inc = (p1_reg[31:0] + 32'd65535) >> 16;
        ta = win_arg(pha_reg);
        tb = win_arg(phb_reg);
        rs0 = (p0_reg + 51'sd32768) >>> 16;
        rs1 = (p1_reg + 51'sd32768) >>> 16;
        sum0 = 52'(accl_reg) + 52'(p0_reg) + 52'sd16384;
        sum1 = 52'(accr_reg) + 52'(p1_reg) + 52'sd16384;
        gl = SB'((p0_reg + 51'sd16384) >>> 15);
        gr = SB'((p1_reg + 51'sd16384) >>> 15);
        if (wp_reg >= dmoda_reg)
        begin
            ba_w = {1'b0, wp_reg} - {1'b0, dmoda_reg};
        end
        else
        begin
            ba_w = {1'b0, wp_reg} + DEPTH_W - {1'b0, dmoda_reg};
        end
        if (wp_reg >= dmodb_reg)
        begin
            bb_w = {1'b0, wp_reg} - {1'b0, dmodb_reg};
        end
        else
        begin
            bb_w = {1'b0, wp_reg} + DEPTH_W - {1'b0, dmodb_reg};
        end
        ba = ba_w[AW-1:0];
        bb = bb_w[AW-1:0];
        aa = (ba == '0) ? LAST_POS : ba - AW'(1);
        ab = (bb == '0) ? LAST_POS : bb - AW'(1);
    end

    // multiplier operand selection per step
    always_comb
    begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        case (step_reg)
            STEP_GATE:
            begin
                a0 = 33'(signed'({1'b0, gdps_pkg::UNITY_GAIN - gain_reg}));
                b0 = gdps_pkg::ATTACK_COEF;
                a1 = 33'(signed'({1'b0, gain_reg}));
                b1 = gdps_pkg::RELEASE_COEF;
            end
            STEP_GAIN:
            begin
                a0 = signed'({1'b0, pha_reg});
                b0 = signed'({3'b0, cfg.grain_length});
                a1 = signed'({1'b0, phb_reg});
                b1 = signed'({3'b0, cfg.grain_length});
            end
            STEP_DELAY:
            begin
                a0 = 33'(l_reg);
                b0 = signed'({2'b0, gain_reg});
                a1 = 33'(r_reg);
                b1 = signed'({2'b0, gain_reg});
            end
            STEP_WRITE:
            begin
                a0 = 33'(signed'({1'b0, ta}));
                b0 = signed'({1'b0, ta});
                a1 = 33'(signed'({1'b0, tb}));
                b1 = signed'({1'b0, tb});
            end
            STEP_RD_BA:
            begin
                a0 = 33'(signed'({1'b0, p0_reg[32:16]}));
                b0 = signed'(gdps_pkg::SIN_C3);
                a1 = 33'(signed'({1'b0, p1_reg[32:16]}));
                b1 = signed'(gdps_pkg::SIN_C3);
            end
            STEP_RD_AA:
            begin
                a0 = 33'(signed'({1'b0, t2a_reg}));
                b0 = signed'(gdps_pkg::SIN_C2 - {1'b0, p0_reg[32:16]});
                a1 = 33'(signed'({1'b0, t2b_reg}));
                b1 = signed'(gdps_pkg::SIN_C2 - {1'b0, p1_reg[32:16]});
            end
            STEP_RD_BB:
            begin
                a0 = 33'(signed'({1'b0, t2a_reg}));
                b0 = signed'(gdps_pkg::SIN_C1 - {1'b0, p0_reg[32:16]});
                a1 = 33'(signed'({1'b0, t2b_reg}));
                b1 = signed'(gdps_pkg::SIN_C1 - {1'b0, p1_reg[32:16]});
            end
            STEP_RD_AB:
            begin
                a0 = 33'(signed'({1'b0, ta}));
                b0 = signed'(gdps_pkg::SIN_C0 - {1'b0, p0_reg[32:16]});
                a1 = 33'(signed'({1'b0, tb}));
                b1 = signed'(gdps_pkg::SIN_C0 - {1'b0, p1_reg[32:16]});
            end
            STEP_SQUARE:
            begin
                a0 = 33'(signed'({1'b0, p0_reg[32:16]}));
                b0 = signed'({1'b0, p0_reg[32:16]});
                a1 = 33'(signed'({1'b0, p1_reg[32:16]}));
                b1 = signed'({1'b0, p1_reg[32:16]});
            end
            STEP_INTERP_A:
            begin
                a0 = 33'(hist_l_reg[1]) - 33'(hist_l_reg[0]);
                b0 = signed'({2'b0, fa_reg});
                a1 = 33'(hist_r_reg[1]) - 33'(hist_r_reg[0]);
                b1 = signed'({2'b0, fa_reg});
            end
            STEP_INTERP_B:
            begin
                a0 = 33'(hist_l_reg[3]) - 33'(hist_l_reg[2]);
                b0 = signed'({2'b0, fb_reg});
                a1 = 33'(hist_r_reg[3]) - 33'(hist_r_reg[2]);
                b1 = signed'({2'b0, fb_reg});
            end
            STEP_WIN_A:
            begin
                a0 = 33'(tapla_reg);
                b0 = signed'({2'b0, wa_reg});
                a1 = 33'(tapra_reg);
                b1 = signed'({2'b0, wa_reg});
            end
            STEP_WIN_B:
            begin
                a0 = 33'(taplb_reg);
                b0 = signed'({2'b0, wb_reg});
                a1 = 33'(taprb_reg);
                b1 = signed'({2'b0, wb_reg});
            end
            STEP_DRY:
            begin
                a0 = 33'(l_reg);
                b0 = signed'({2'b0, cfg.dry_gain});
                a1 = 33'(r_reg);
                b1 = signed'({2'b0, cfg.dry_gain});
            end
            STEP_WET:
            begin
                a0 = 33'(tl_reg);
                b0 = signed'({2'b0, cfg.wet_gain});
                a1 = 33'(tr_reg);
                b1 = signed'({2'b0, cfg.wet_gain});
            end
            default:
            begin
                a0 = '0;
            end
        endcase
    end

    assign prod0 = a0 * b0;
    assign prod1 = a1 * b1;

    // gate gain update
    always_comb
    begin
        gain_next = gain_reg;
        if (!cfg.gate_enable)
        begin
            gain_next = gdps_pkg::UNITY_GAIN;
        end
        else if (att_reg)
        begin
            gain_next = gain_reg + att_inc[15:0];
        end
        else if (rel_reg)
        begin
            gain_next = gain_reg - rel_inc[15:0];
        end
    end

    // history ram port
    always_comb
    begin
        ram_en = 1'b0;
        ram_we = 1'b0;
        ram_addr = ba;
        ram_wdata = {gl, gr};
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_WRITE:
                begin
                    ram_en = 1'b1;
                    ram_we = 1'b1;
                    ram_addr = wp_reg;
                end
                STEP_RD_BA:
                begin
                    ram_en = 1'b1;
                    ram_addr = addr_reg[0];
                end
                STEP_RD_AA:
                begin
                    ram_en = 1'b1;
                    ram_addr = addr_reg[1];
                end
                STEP_RD_BB:
                begin
                    ram_en = 1'b1;
                    ram_addr = addr_reg[2];
                end
                STEP_RD_AB:
                begin
                    ram_en = 1'b1;
                    ram_addr = addr_reg[3];
                end
                default:
                begin
                    ram_en = 1'b0;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cfg.bypass ? ST_DONE : ST_RUN;
                    step_next = STEP_GATE;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_OUT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= STEP_GATE;
            gain_reg <= gdps_pkg::UNITY_GAIN;
            pha_reg <= 32'h0000_0000;
            phb_reg <= 32'h8000_0000;
            wp_reg <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (state_reg == ST_RUN)
            begin
                if (step_reg == STEP_GATE)
                begin
                    pha_reg <= pha_reg + cfg.phase_step;
                    phb_reg <= phb_reg + cfg.phase_step;
                end
                if (step_reg == STEP_GAIN)
                begin
                    gain_reg <= gain_next;
                end
                if (step_reg == STEP_OUT)
                begin
                    if (wp_reg == LAST_POS)
                    begin
                        wp_reg <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        wp_reg <= wp_reg + AW'(1);
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            l_reg <= item.left_sample;
            r_reg <= item.right_sample;
            res_reg.left_out <= item.left_sample;
            res_reg.right_out <= item.right_sample;
        end
        if (state_reg == ST_RUN)
        begin
            p0_reg <= prod0;
            p1_reg <= prod1;
            case (step_reg)
                STEP_GATE:
                begin
                    att_reg <= gate_open && (gain_reg < gdps_pkg::UNITY_GAIN);
                    rel_reg <= !gate_open && (gain_reg != 16'd0);
                end
                STEP_DELAY:
                begin
                    dmoda_reg <= mod_depth(p0_reg[47:32]);
                    dmodb_reg <= mod_depth(p1_reg[47:32]);
                    fa_reg <= p0_reg[31:16];
                    fb_reg <= p1_reg[31:16];
                end
                STEP_WRITE:
                begin
                    addr_reg[0] <= ba;
                    addr_reg[1] <= aa;
                    addr_reg[2] <= bb;
                    addr_reg[3] <= ab;
                end
                STEP_RD_BA:
                begin
                    t2a_reg <= p0_reg[32:16];
                    t2b_reg <= p1_reg[32:16];
                end
                STEP_RD_AA:
                begin
                    hist_l_reg[0] <= entry_ok(addr_reg[0], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[2*SB-1:SB]) : '0;
                    hist_r_reg[0] <= entry_ok(addr_reg[0], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[SB-1:0]) : '0;
                end
                STEP_RD_BB:
                begin
                    hist_l_reg[1] <= entry_ok(addr_reg[1], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[2*SB-1:SB]) : '0;
                    hist_r_reg[1] <= entry_ok(addr_reg[1], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[SB-1:0]) : '0;
                end
                STEP_RD_AB:
                begin
                    hist_l_reg[2] <= entry_ok(addr_reg[2], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[2*SB-1:SB]) : '0;
                    hist_r_reg[2] <= entry_ok(addr_reg[2], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[SB-1:0]) : '0;
                end
                STEP_SQUARE:
                begin
                    hist_l_reg[3] <= entry_ok(addr_reg[3], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[2*SB-1:SB]) : '0;
                    hist_r_reg[3] <= entry_ok(addr_reg[3], wp_reg, wrapped_reg) ?
                                     signed'(ram_rdata[SB-1:0]) : '0;
                end
                STEP_INTERP_A:
                begin
                    wa_reg <= (p0_reg[33:17] > 17'(gdps_pkg::UNITY_GAIN)) ?
                              gdps_pkg::UNITY_GAIN : p0_reg[32:17];
                    wb_reg <= (p1_reg[33:17] > 17'(gdps_pkg::UNITY_GAIN)) ?
                              gdps_pkg::UNITY_GAIN : p1_reg[32:17];
                end
                STEP_INTERP_B:
                begin
                    tapla_reg <= (SB + 1)'(hist_l_reg[0]) + rs0[SB:0];
                    tapra_reg <= (SB + 1)'(hist_r_reg[0]) + rs1[SB:0];
                end
                STEP_WIN_A:
                begin
                    taplb_reg <= (SB + 1)'(hist_l_reg[2]) + rs0[SB:0];
                    taprb_reg <= (SB + 1)'(hist_r_reg[2]) + rs1[SB:0];
                end
                STEP_WIN_B:
                begin
                    accl_reg <= p0_reg;
                    accr_reg <= p1_reg;
                end
                STEP_DRY:
                begin
                    tl_reg <= (SB + 2)'(sum0 >>> 15);
                    tr_reg <= (SB + 2)'(sum1 >>> 15);
                end
                STEP_WET:
                begin
                    accl_reg <= p0_reg;
                    accr_reg <= p1_reg;
                end
                STEP_OUT:
                begin
                    res_reg.left_out <= sat(sum0 >>> 15);
                    res_reg.right_out <= sat(sum1 >>> 15);
                end
                default:
                begin
                    att_reg <= att_reg;
                end
            endcase
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign result = res_reg;

`ifndef ASSERT_OFF
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_POS)
        else $error("write position beyond history depth");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= gdps_pkg::UNITY_GAIN)
        else $error("gate gain above unity");

    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && !cfg.bypass) |=>
        (state_reg == ST_RUN && step_reg == STEP_GATE))
        else $error("item did not enter the schedule");

    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_RUN && step_reg == STEP_OUT) |=> $stable(wp_reg))
        else $error("write position moved outside last step");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_RUN && step_reg == STEP_WRITE))
        else $error("history write outside the write step");
`endif

endmodule

// ===== hdl/granular_delay_pitch_shifter_top.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// in       | in_valid / in_ready   | in_data: left_sample, right_sample
// out      | out_valid / out_ready | out_data: left_out, right_out
// cfg      | cfg_we                | cfg_index, cfg_data (write only)
//
// an item runs the core schedule from input transfer to out_valid, bypass skips it; the
// next input transfer can be taken in the cycle after the core hands its result over
// the schedule is 16 steps on two shared multipliers and one single-port history ram
// reset clears control state only; history entries not yet written read as zero
// a held result waits in the output register while the next item is accepted
module granular_delay_pitch_shifter_top #(
    parameter int HISTORY_DEPTH = gdps_pkg::HISTORY_DEPTH_DEF,
    parameter int WINDOW_TABLE_BITS = gdps_pkg::WINDOW_TABLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  gdps_pkg::in_pair_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output gdps_pkg::out_pair_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [gdps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [gdps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SB = gdps_pkg::SAMPLE_BITS;

    gdps_pkg::cfg_t cfg_reg;
    gdps_pkg::out_pair_t result, out_data_reg;
    logic out_valid_reg;
    logic core_idle, res_valid, res_take;
    logic ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [2*SB-1:0] ram_wdata, ram_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= 32'sd0;
            cfg_reg.grain_length <= 15'd2016;
            cfg_reg.gate_enable <= 1'b1;
            cfg_reg.gate_threshold <= 23'd14917;
            cfg_reg.dry_gain <= 16'd0;
            cfg_reg.wet_gain <= 16'd32768;
            cfg_reg.bypass <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gdps_pkg::CFG_PHASE_STEP: cfg_reg.phase_step <= signed'(cfg_data);
                gdps_pkg::CFG_GRAIN_LENGTH: cfg_reg.grain_length <= cfg_data[14:0];
                gdps_pkg::CFG_GATE_ENABLE: cfg_reg.gate_enable <= cfg_data[0];
                gdps_pkg::CFG_GATE_THRESHOLD: cfg_reg.gate_threshold <= cfg_data[22:0];
                gdps_pkg::CFG_DRY_GAIN: cfg_reg.dry_gain <= cfg_data[15:0];
                gdps_pkg::CFG_WET_GAIN: cfg_reg.wet_gain <= cfg_data[15:0];
                gdps_pkg::CFG_BYPASS: cfg_reg.bypass <= cfg_data[0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_ready = core_idle;
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    gdps_core #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .WINDOW_TABLE_BITS(WINDOW_TABLE_BITS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .start(in_valid && in_ready),
        .item(in_data),
        .cfg(cfg_reg),
        .idle(core_idle),
        .res_valid(res_valid),
        .res_take(res_take),
        .result(result),
        .ram_en(ram_en),
        .ram_we(ram_we),
        .ram_addr(ram_addr),
        .ram_wdata(ram_wdata),
        .ram_rdata(ram_rdata)
    );

    // both channels share one wide history ram
    gdps_ram #(
        .WIDTH(2 * SB),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk(clk),
        .en(ram_en),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule
